/* sv/mipf_pkg.sv */
// shared types, codes and helper functions for the masked ip filter table
package mipf_pkg;

    // command codes
    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    // value stored into a freed slot
    localparam logic [31:0] FREED_VALUE = 32'hffff_ffff;
    localparam logic [7:0]  BYTE_FULL   = 8'hff;

    // controller to datapath commands
    typedef struct packed {
        logic start;
        logic scan;
        logic finish;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } ctrl_stat_t;

    // one mask bit per nonzero byte
    function automatic logic [3:0] mask_of_value(input logic [31:0] v);
        logic [3:0] m;
        m = 4'd0;
        for (int k = 0; k < 4; k++)
        begin
            m[k] = (v[8*k +: 8] != 8'd0);
        end
        return m;
    endfunction

    // byte mask to bit mask
    function automatic logic [31:0] expand_mask(input logic [3:0] m);
        logic [31:0] r;
        r = 32'd0;
        for (int k = 0; k < 4; k++)
        begin
            r[8*k +: 8] = m[k] ? BYTE_FULL : 8'd0;
        end
        return r;
    endfunction

endpackage

/* sv/mipf_ctrl.sv */
// controller state machine for the masked ip filter table
module mipf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  mipf_pkg::ctrl_stat_t stat,
    output mipf_pkg::ctrl_cmd_t  cmd
);
    import mipf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // input side busy whenever an item is in flight
    assign in_stall = (state_reg != ST_IDLE);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/mipf_datapath.sv */
// rule memory, scan pipeline, use count and result register
module mipf_datapath #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mipf_pkg::ctrl_cmd_t  cmd,
    output mipf_pkg::ctrl_stat_t stat,
    input  logic                 cfg_write_en,
    input  logic                 cfg_write_data,
    input  logic [1:0]           in_cmd,
    input  logic [31:0]          in_address,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 deny,
    output logic [1:0]           status,
    output logic [9:0]           entry_index,
    output logic [10:0]          entry_count
);
    import mipf_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // table entry is {byte mask, value}
    logic [35:0]   table_mem [TABLE_DEPTH];
    logic [35:0]   rd_data_reg;

    logic [1:0]    cmd_reg;
    logic [31:0]   addr_reg;
    logic [CW-1:0] rd_ptr_reg;
    logic [CW-1:0] rd_ptr_next;
    logic          cmp_valid_reg;
    logic          cmp_valid_next;
    logic [AW-1:0] cmp_ptr_reg;
    logic [AW-1:0] cmp_ptr_next;
    logic          hit_reg;
    logic          hit_next;
    logic [AW-1:0] hit_idx_reg;
    logic [AW-1:0] hit_idx_next;
    logic [CW-1:0] used_reg;
    logic [CW-1:0] used_next;
    logic          mode_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          deny_reg;
    logic [1:0]    status_reg;
    logic [9:0]    entry_index_reg;
    logic [10:0]   entry_count_reg;

    logic          cmd_known;
    logic          issue;
    logic          entry_match;
    logic          match_now;
    logic [3:0]    addr_mask;
    logic [3:0]    rd_mask;
    logic [31:0]   rd_value;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [35:0]   wr_data;
    logic          res_deny;
    logic [1:0]    res_status;
    logic [AW-1:0] res_idx;
    logic [31:0]   idx_wide;
    logic [31:0]   count_wide;
    logic          table_full;

    assign cmd_known = (cmd_reg == CMD_LOOKUP) || (cmd_reg == CMD_ADD)
                    || (cmd_reg == CMD_REMOVE);
    assign addr_mask = mask_of_value(addr_reg);
    assign rd_mask   = rd_data_reg[35:32];
    assign rd_value  = rd_data_reg[31:0];

    // per-command match test on the entry just read
    always_comb
    begin
        case (cmd_reg)
            CMD_LOOKUP: entry_match = ((addr_reg & expand_mask(rd_mask)) == rd_value);
            CMD_ADD:    entry_match = (rd_value == FREED_VALUE);
            CMD_REMOVE: entry_match = (rd_mask == addr_mask) && (rd_value == addr_reg);
            default:    entry_match = 1'b0;
        endcase
    end

    assign match_now = cmp_valid_reg && !hit_reg && entry_match;
    assign issue     = cmd.scan && cmd_known && !hit_reg && !match_now
                    && (rd_ptr_reg < used_reg);

    // scan pipeline control
    always_comb
    begin
        rd_ptr_next    = rd_ptr_reg;
        cmp_valid_next = 1'b0;
        cmp_ptr_next   = cmp_ptr_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        if (cmd.start)
        begin
            rd_ptr_next = '0;
            hit_next    = 1'b0;
        end
        else
        begin
            if (issue)
            begin
                rd_ptr_next    = rd_ptr_reg + CW'(1);
                cmp_valid_next = 1'b1;
                cmp_ptr_next   = rd_ptr_reg[AW-1:0];
            end
            if (match_now)
            begin
                hit_next     = 1'b1;
                hit_idx_next = cmp_ptr_reg;
            end
        end
    end

    assign stat.scan_done = !cmd_known || hit_reg
                         || ((rd_ptr_reg == used_reg) && !cmp_valid_reg);
    assign stat.out_free  = !out_valid_reg || !out_stall;

    // result and table update at the end of an item
    assign table_full = (used_reg == CW'(TABLE_DEPTH));

    always_comb
    begin
        res_deny   = 1'b0;
        res_status = STATUS_OK;
        res_idx    = '0;
        wr_en      = 1'b0;
        wr_addr    = hit_idx_reg;
        wr_data    = {addr_mask, addr_reg};
        used_next  = used_reg;
        case (cmd_reg)
            CMD_LOOKUP:
            begin
                res_deny = hit_reg ? mode_reg : !mode_reg;
                res_idx  = hit_reg ? hit_idx_reg : '0;
            end
            CMD_ADD:
            begin
                if (hit_reg)
                begin
                    wr_en   = cmd.finish;
                    res_idx = hit_idx_reg;
                end
                else if (table_full)
                begin
                    res_status = STATUS_FULL;
                end
                else
                begin
                    wr_en   = cmd.finish;
                    wr_addr = used_reg[AW-1:0];
                    res_idx = used_reg[AW-1:0];
                    if (cmd.finish)
                    begin
                        used_next = used_reg + CW'(1);
                    end
                end
            end
            CMD_REMOVE:
            begin
                if (hit_reg)
                begin
                    wr_en   = cmd.finish;
                    wr_data = {addr_mask, FREED_VALUE};
                    res_idx = hit_idx_reg;
                end
                else
                begin
                    res_status = STATUS_NOT_FOUND;
                end
            end
            default:
            begin
                res_status = STATUS_OK;
            end
        endcase
    end

    assign idx_wide   = 32'(res_idx);
    assign count_wide = 32'(used_next);

    assign out_valid_next = cmd.finish ? 1'b1 : (out_valid_reg && out_stall);

    // rule memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_data_reg <= table_mem[rd_ptr_reg[AW-1:0]];
        end
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            used_reg      <= '0;
            mode_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_ptr_reg    <= rd_ptr_next;
            cmp_valid_reg <= cmp_valid_next;
            hit_reg       <= hit_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                mode_reg <= cfg_write_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmp_ptr_reg <= cmp_ptr_next;
        hit_idx_reg <= hit_idx_next;
        if (cmd.start)
        begin
            cmd_reg  <= in_cmd;
            addr_reg <= in_address;
        end
        if (cmd.finish)
        begin
            deny_reg        <= res_deny;
            status_reg      <= res_status;
            entry_index_reg <= idx_wide[9:0];
            entry_count_reg <= count_wide[10:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign deny        = deny_reg;
    assign status      = status_reg;
    assign entry_index = entry_index_reg;
    assign entry_count = entry_count_reg;

endmodule

/* sv/masked_ip_filter_table_top.sv */
// top level of the masked ip filter table
//
//  channel  signals                           direction  accepted when
//  in       in_valid in_stall cmd address     in         in_valid && !in_stall
//  out      out_valid out_stall deny status   out        out_valid && !out_stall
//           entry_index entry_count
//  cfg      cfg_write_en cfg_write_data       in         cfg_write_en
//
// an item holds the block while the used slots are scanned through the single
// memory read port, which scans one entry per cycle;
// a lookup, add or remove that hits stops the scan at the hit.
// reset clears the use count and sets filter_mode to 1; the rules need no clearing.
// in_stall is high from acceptance until the result beat is loaded into the
// output register; a stalled output holds the next result in the final state.
module masked_ip_filter_table_top #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [31:0] address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        deny,
    output logic [1:0]  status,
    output logic [9:0]  entry_index,
    output logic [10:0] entry_count
);
    import mipf_pkg::*;

    ctrl_cmd_t  ctl_cmd;
    ctrl_stat_t ctl_stat;

    // sequencer
    mipf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (ctl_stat),
        .cmd      (ctl_cmd)
    );

    // table and result path
    mipf_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (ctl_cmd),
        .stat           (ctl_stat),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_cmd         (cmd),
        .in_address     (address),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .deny           (deny),
        .status         (status),
        .entry_index    (entry_index),
        .entry_count    (entry_count)
    );

    // accepted beat keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("block not busy after accepting a beat");

    // a deny verdict only comes with ok status
    a_deny_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && deny) |-> (status == STATUS_OK))
        else $error("deny with non-ok status");

    // failures report no slot
    a_fail_no_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STATUS_FULL || status == STATUS_NOT_FOUND))
        |-> (entry_index == 10'd0))
        else $error("failed command reports a slot");

    // a new result never lands on one still stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(entry_count))
        else $error("stalled result overwritten");

endmodule

/* bench/testbench.sv */
// testbench for the masked ip filter table: directed and random traffic checked beat by beat
`timescale 1ns / 100ps

module testbench;
    import mipf_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam int LONG_HOLD   = 400;
    localparam int MAX_REPORTS = 10;
    localparam int GROWTH_CAP  = 120;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic       MODE_ALLOW = 1'b0;
    localparam logic       MODE_BAN   = 1'b1;

    typedef struct packed {
        logic        deny;
        logic [1:0]  status;
        logic [9:0]  index;
        logic [10:0] count;
    } filter_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic        cfg_write_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  cmd;
    logic [31:0] address;
    logic        out_valid;
    logic        out_stall;
    logic        deny;
    logic [1:0]  status;
    logic [9:0]  entry_index;
    logic [10:0] entry_count;

    // shadow copy of the rule table and the mode register
    logic [31:0] shadow_value [TABLE_DEPTH];
    logic [3:0]  shadow_mask [TABLE_DEPTH];
    int          shadow_used;
    logic        shadow_mode;

    filter_result_t pending_results [$];
    logic [31:0]    rule_pool [$];

    int error_count;
    int n_lookup;
    int n_add;
    int n_remove;
    int n_other;
    int n_beats_out;
    int peak_used;

    bit idle_on;
    bit stall_on;
    bit long_hold_req;
    bit hold_active;

    masked_ip_filter_table_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .address(address),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .deny(deny),
        .status(status),
        .entry_index(entry_index),
        .entry_count(entry_count)
    );

    // clock
    always #2 clk = ~clk;

    // one bit per nonzero byte of a rule value
    function automatic logic [3:0] nonzero_bytes(input logic [31:0] v);
        return {|v[31:24], |v[23:16], |v[15:8], |v[7:0]};
    endfunction

    // byte mask widened to a bit mask
    function automatic logic [31:0] byte_wildcard_mask(input logic [3:0] m);
        return {{8{m[3]}}, {8{m[2]}}, {8{m[1]}}, {8{m[0]}}};
    endfunction

    // random rule value, some bytes zero as wildcards
    function automatic logic [31:0] random_rule_value();
        logic [31:0] v;
        for (int k = 0; k < 4; k++)
        begin
            v[8*k +: 8] = ($urandom_range(0, 9) < 3) ? 8'd0 : 8'($urandom_range(1, 255));
        end
        return v;
    endfunction

    // expected verdict of one command, updating the shadow table
    function automatic filter_result_t compute_filter_result(input logic [1:0] c,
                                                             input logic [31:0] a);
        filter_result_t r;
        bit             hit;
        int             slot;
        logic [3:0]     m;
        r = '0;
        hit = 1'b0;
        slot = 0;
        m = nonzero_bytes(a);
        case (c)
            CMD_LOOKUP:
            begin
                for (int i = 0; i < shadow_used; i++)
                begin
                    if (!hit && ((a & byte_wildcard_mask(shadow_mask[i])) == shadow_value[i]))
                    begin
                        hit = 1'b1;
                        slot = i;
                    end
                end
                r.deny = hit ? shadow_mode : !shadow_mode;
                r.index = slot[9:0];
            end
            CMD_ADD:
            begin
                // first freed slot wins, else append
                slot = shadow_used;
                for (int i = shadow_used - 1; i >= 0; i--)
                begin
                    if (shadow_value[i] == FREED_VALUE)
                        slot = i;
                end
                if (slot == shadow_used && shadow_used >= TABLE_DEPTH)
                begin
                    r.status = STATUS_FULL;
                end
                else
                begin
                    if (slot == shadow_used)
                        shadow_used++;
                    shadow_value[slot] = a;
                    shadow_mask[slot] = m;
                    r.index = slot[9:0];
                end
            end
            CMD_REMOVE:
            begin
                r.status = STATUS_NOT_FOUND;
                for (int i = 0; i < shadow_used; i++)
                begin
                    if (!hit && shadow_mask[i] == m && shadow_value[i] == a)
                    begin
                        hit = 1'b1;
                        slot = i;
                    end
                end
                if (hit)
                begin
                    shadow_value[slot] = FREED_VALUE;
                    r.status = STATUS_OK;
                    r.index = slot[9:0];
                end
            end
            default:
            begin
            end
        endcase
        r.count = shadow_used[10:0];
        return r;
    endfunction

    // offer one beat, wait for acceptance, record what should come back
    task automatic send_beat(input logic [1:0] c, input logic [31:0] a);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        address <= a;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(compute_filter_result(c, a));
        case (c)
            CMD_LOOKUP: n_lookup++;
            CMD_ADD:
            begin
                n_add++;
                rule_pool.push_back(a);
            end
            CMD_REMOVE: n_remove++;
            default: n_other++;
        endcase
        if (shadow_used > peak_used)
            peak_used = shadow_used;
    endtask

    // drop valid and wait until every result has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write the mode register while the block is idle
    task automatic set_filter_mode(input logic m);
        wait_idle();
        cfg_write_en <= 1'b1;
        cfg_write_data <= m;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        shadow_mode = m;
        @(posedge clk);
    endtask

    // add, remove, freed slots and the all-ones cases, mode at reset value
    task automatic test_rule_edits();
        send_beat(CMD_LOOKUP, 32'h0102_0304);
        send_beat(CMD_ADD, 32'h0a00_0000);
        send_beat(CMD_ADD, 32'hc0a8_0107);
        send_beat(CMD_LOOKUP, 32'h0a7f_0001);
        send_beat(CMD_LOOKUP, 32'hc0a8_0107);
        send_beat(CMD_LOOKUP, 32'h0b00_0000);
        // all-ones rule is stored, then taken as free by the next add
        send_beat(CMD_ADD, FREED_VALUE);
        send_beat(CMD_LOOKUP, FREED_VALUE);
        send_beat(CMD_ADD, 32'hac10_0000);
        send_beat(CMD_REMOVE, 32'h0a00_0000);
        send_beat(CMD_REMOVE, 32'hc0a8_0107);
        // freed full-mask slot matches the broadcast address
        send_beat(CMD_LOOKUP, FREED_VALUE);
        send_beat(CMD_REMOVE, FREED_VALUE);
        send_beat(CMD_REMOVE, 32'h0102_0304);
        send_beat(CMD_UNUSED, 32'h5a5a_5a5a);
        // all-wildcard rule matches everything
        send_beat(CMD_ADD, 32'h0000_0000);
        send_beat(CMD_LOOKUP, 32'h0000_0000);
        send_beat(CMD_LOOKUP, FREED_VALUE);
    endtask

    // verdicts under both modes
    task automatic test_mode_switch();
        set_filter_mode(MODE_ALLOW);
        send_beat(CMD_LOOKUP, 32'h1234_5678);
        send_beat(CMD_REMOVE, 32'h0000_0000);
        send_beat(CMD_LOOKUP, 32'h1234_5678);
        send_beat(CMD_LOOKUP, 32'hac10_ffff);
        set_filter_mode(MODE_BAN);
        send_beat(CMD_LOOKUP, 32'hac10_ffff);
        send_beat(CMD_LOOKUP, 32'h1234_5678);
        wait_idle();
    endtask

    // receiver holds off for a long stretch while beats keep coming
    task automatic test_output_hold();
        long_hold_req = 1'b1;
        while (!hold_active)
            @(posedge clk);
        repeat (8)
            send_beat($urandom_range(0, 1) ? CMD_LOOKUP : CMD_ADD, random_rule_value());
        wait_idle();
    endtask

    // mixed random traffic, lookups and removes often on rules that were added
    task automatic test_random_traffic(input int n_items);
        logic [1:0]  c;
        logic [31:0] a;
        int          pick;
        bit          has_freed;
        repeat (n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                c = CMD_LOOKUP;
            else if (pick < 70)
                c = CMD_ADD;
            else if (pick < 96)
                c = CMD_REMOVE;
            else
                c = CMD_UNUSED;
            // keep the table short so scans stay quick
            if (c == CMD_ADD && shadow_used >= GROWTH_CAP)
            begin
                has_freed = 1'b0;
                for (int i = 0; i < shadow_used; i++)
                begin
                    if (shadow_value[i] == FREED_VALUE)
                        has_freed = 1'b1;
                end
                if (!has_freed)
                    c = CMD_REMOVE;
            end
            pick = $urandom_range(0, 9);
            case (c)
                CMD_LOOKUP:
                begin
                    if (pick < 5 && rule_pool.size() > 0)
                    begin
                        a = rule_pool[$urandom_range(0, rule_pool.size() - 1)];
                        a = a | (32'($urandom) & ~byte_wildcard_mask(nonzero_bytes(a)));
                    end
                    else if (pick == 5)
                        a = FREED_VALUE;
                    else
                        a = $urandom;
                end
                CMD_ADD:
                    a = (pick == 0) ? FREED_VALUE : random_rule_value();
                CMD_REMOVE:
                begin
                    if (pick < 6 && rule_pool.size() > 0)
                        a = rule_pool[$urandom_range(0, rule_pool.size() - 1)];
                    else if (pick == 6)
                        a = FREED_VALUE;
                    else
                        a = random_rule_value();
                end
                default:
                    a = $urandom;
            endcase
            send_beat(c, a);
        end
    endtask

    // receiver: random stall bursts, plus the long hold on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                hold_active = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
                hold_active = 1'b0;
                long_hold_req = 1'b0;
            end
            else if (stall_on && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        filter_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_beats_out++;
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t unexpected result beat: deny %0d status %0d index %0d count %0d",
                             $time, deny, status, entry_index, entry_count);
            end
            else
            begin
                want = pending_results.pop_front();
                if (deny !== want.deny || status !== want.status ||
                    entry_index !== want.index || entry_count !== want.count)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                    begin
                        $display("%0t mismatch: expected deny %0d status %0d index %0d count %0d",
                                 $time, want.deny, want.status, want.index, want.count);
                        $display("%0t             got deny %0d status %0d index %0d count %0d",
                                 $time, deny, status, entry_index, entry_count);
                    end
                end
            end
        end
    end

    // watchdog
    initial
    begin
        #40_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // test sequence
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_write_data = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_LOOKUP;
        address = 32'd0;
        out_stall = 1'b0;
        shadow_used = 0;
        shadow_mode = MODE_BAN;
        error_count = 0;
        n_lookup = 0;
        n_add = 0;
        n_remove = 0;
        n_other = 0;
        n_beats_out = 0;
        peak_used = 0;
        idle_on = 1'b1;
        stall_on = 1'b1;
        long_hold_req = 1'b0;
        hold_active = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_rule_edits();
        test_mode_switch();
        test_output_hold();

        set_filter_mode(MODE_ALLOW);
        test_random_traffic(135);
        set_filter_mode(MODE_BAN);
        test_random_traffic(135);
        set_filter_mode(MODE_ALLOW);
        test_random_traffic(135);
        // closing stretch with no idling on either side
        idle_on = 1'b0;
        stall_on = 1'b0;
        set_filter_mode(MODE_BAN);
        test_random_traffic(145);

        wait_idle();
        repeat (TABLE_DEPTH + 16) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0d expected result beats never arrived", pending_results.size());
            error_count += pending_results.size();
        end

        $display("ran %0d lookups, %0d adds, %0d removes, %0d unused codes; %0d result beats",
                 n_lookup, n_add, n_remove, n_other, n_beats_out);
        $display("table reached %0d of %0d slots, both filter modes, long output hold; %0d errors",
                 peak_used, TABLE_DEPTH, error_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
